// File: rtl/ufd_pkg.sv
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared constants and controller/datapath handshake types for the serial
// frame deframer.
// ----------------------------------------------------------------------------
package ufd_pkg;

    localparam logic [7:0] SOF_BYTE  = 8'hFE;
    localparam logic [7:0] CMD_RADIO = 8'h84;
    localparam logic [7:0] CMD_RESET = 8'h80;
    localparam logic [7:0] CMD_PONG  = 8'h81;
    localparam logic [7:0] RSSI_OFS  = 8'd73;

    typedef struct packed {
        logic take;
        logic len_ph;
        logic body_ph;
        logic chk_ph;
        logic put;
    } t_ufd_cmd;

    typedef struct packed {
        logic fire;
        logic sof;
        logic len_bad;
        logic body_done;
        logic chk_ok;
        logic drop_short;
        logic out_free;
        logic last;
    } t_ufd_stat;

endpackage

// File: rtl/ufd_if.sv
// ----------------------------------------------------------------------------
// ufd_if
// Valid/ready channels: received serial bytes in, replayed frame items out.
// ----------------------------------------------------------------------------
interface ufd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufd_out_if;
    logic              valid;
    logic              ready;
    logic              frame_kind;
    logic [7:0]        resp_code;
    logic              has_data;
    logic [7:0]        data_byte;
    logic [5:0]        byte_index;
    logic [5:0]        body_length;
    logic signed [7:0] rssi_dbm;
    logic [7:0]        link_quality;
    logic [15:0]       fw_version;
    logic              last;

    modport source (
        output valid, input ready,
        output frame_kind, output resp_code, output has_data, output data_byte,
        output byte_index, output body_length, output rssi_dbm,
        output link_quality, output fw_version, output last
    );
    modport sink (
        input valid, output ready,
        input frame_kind, input resp_code, input has_data, input data_byte,
        input byte_index, input body_length, input rssi_dbm,
        input link_quality, input fw_version, input last
    );
endinterface

// File: rtl/ufd_ctrl.sv
// ----------------------------------------------------------------------------
// ufd_ctrl
// Frame parse and replay sequencer: hunt, length, body, checksum, then a
// read/put loop over the stored bytes.
// ----------------------------------------------------------------------------
module ufd_ctrl import ufd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ufd_stat i_stat,
    output t_ufd_cmd  o_cmd
);

    typedef enum logic [5:0] {
        ST_HUNT = 6'b000001,
        ST_LEN  = 6'b000010,
        ST_BODY = 6'b000100,
        ST_CHK  = 6'b001000,
        ST_READ = 6'b010000,
        ST_PUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd.take    = (r_state == ST_HUNT) || (r_state == ST_LEN) ||
                        (r_state == ST_BODY) || (r_state == ST_CHK);
        o_cmd.len_ph  = (r_state == ST_LEN);
        o_cmd.body_ph = (r_state == ST_BODY);
        o_cmd.chk_ph  = (r_state == ST_CHK);
        o_cmd.put     = (r_state == ST_PUT) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_HUNT: begin
                if (i_stat.fire && i_stat.sof) n_state = ST_LEN;
            end
            ST_LEN: begin
                if (i_stat.fire) n_state = i_stat.len_bad ? ST_HUNT : ST_BODY;
            end
            ST_BODY: begin
                if (i_stat.fire && i_stat.body_done) n_state = ST_CHK;
            end
            ST_CHK: begin
                if (i_stat.fire) begin
                    n_state = (i_stat.chk_ok && !i_stat.drop_short) ? ST_READ : ST_HUNT;
                end
            end
            ST_READ: begin
                n_state = ST_PUT;
            end
            ST_PUT: begin
                if (o_cmd.put) n_state = i_stat.last ? ST_HUNT : ST_READ;
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.put && i_stat.last) |=> (r_state == ST_HUNT))
        else $error("replay did not end after last item");

    a_put_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.put |-> i_stat.out_free)
        else $error("item put while output register busy");

    a_bad_chk_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHK && i_stat.fire && !i_stat.chk_ok) |=> (r_state == ST_HUNT))
        else $error("bad checksum frame not dropped");

endmodule

// File: rtl/ufd_dp.sv
// ----------------------------------------------------------------------------
// ufd_dp
// Deframer datapath: length and checksum tracking, frame store, frame
// header capture, version register and output register.
// ----------------------------------------------------------------------------
module ufd_dp import ufd_pkg::*; #(
    parameter int BUF_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ufd_in_if.sink     i_rx,
    ufd_out_if.source  o_res,
    input  t_ufd_cmd   i_cmd,
    output t_ufd_stat  o_stat
);

    localparam int         AW      = $clog2(BUF_DEPTH);
    localparam logic [7:0] DEPTH_B = 8'(BUF_DEPTH);

    logic [7:0]  r_mem [BUF_DEPTH];
    logic [7:0]  r_rd_data;

    logic [6:0]  r_len;
    logic [6:0]  r_cnt;
    logic [7:0]  r_chk;
    logic [15:0] r_ver;
    logic [7:0]  r_cmd;
    logic [7:0]  r_b1;
    logic [7:0]  r_b2;
    logic        r_kind;
    logic [5:0]  r_n;
    logic [5:0]  r_idx;
    logic [7:0]  r_rssi;
    logic [7:0]  r_lqi;

    logic        r_o_valid;
    logic        r_o_kind;
    logic [7:0]  r_o_code;
    logic        r_o_has;
    logic [7:0]  r_o_data;
    logic [5:0]  r_o_idx;
    logic [5:0]  r_o_blen;
    logic [7:0]  r_o_rssi;
    logic [7:0]  r_o_lqi;
    logic [15:0] r_o_ver;
    logic        r_o_last;

    logic        fire;
    logic [7:0]  rx_b;
    logic [6:0]  n_cnt;
    logic        is_radio;
    logic        len_short;
    logic        is_ver;
    logic [6:0]  n_body;
    logic [6:0]  rd_addr;
    logic        last_res;

    assign i_rx.ready = i_cmd.take;
    assign fire       = i_rx.valid && i_cmd.take;
    assign rx_b       = i_rx.rx_byte;

    always_comb begin
        n_cnt     = r_cnt + 7'd1;
        is_radio  = (r_cmd == CMD_RADIO);
        len_short = (r_len < 7'd3);
        is_ver    = ((r_cmd == CMD_RESET) || (r_cmd == CMD_PONG)) && !len_short;
        n_body    = is_radio ? (r_len - 7'd3) : (r_len - 7'd1);
        rd_addr   = (r_kind ? 7'd1 : 7'd3) + {1'b0, r_idx};
        last_res  = (r_n == 6'd0) || (r_idx == (r_n - 6'd1));
    end

    always_comb begin
        o_stat.fire       = fire;
        o_stat.sof        = (rx_b == SOF_BYTE);
        o_stat.len_bad    = (rx_b == 8'd0) || (rx_b > DEPTH_B);
        o_stat.body_done  = (n_cnt >= r_len);
        o_stat.chk_ok     = (rx_b == r_chk);
        o_stat.drop_short = is_radio && len_short;
        o_stat.out_free   = !r_o_valid || o_res.ready;
        o_stat.last       = last_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_cnt     <= '0;
            r_chk     <= '0;
            r_ver     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (fire && i_cmd.len_ph) begin
                r_cnt <= '0;
                r_chk <= rx_b;
                r_len <= o_stat.len_bad ? 7'd0 : rx_b[6:0];
            end
            if (fire && i_cmd.body_ph) begin
                r_cnt <= n_cnt;
                r_chk <= r_chk ^ rx_b;
            end
            if (fire && i_cmd.chk_ph && o_stat.chk_ok && is_ver) begin
                r_ver <= {r_b1, r_b2};
            end
            if (i_cmd.put) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr[AW-1:0]];
        if (fire && i_cmd.body_ph) begin
            r_mem[r_cnt[AW-1:0]] <= rx_b;
            if (r_cnt == 7'd0) r_cmd <= rx_b;
            if (r_cnt == 7'd1) r_b1 <= rx_b;
            if (r_cnt == 7'd2) r_b2 <= rx_b;
        end
        if (fire && i_cmd.chk_ph) begin
            r_kind <= !is_radio;
            r_n    <= n_body[5:0];
            r_idx  <= '0;
            r_rssi <= is_radio ? (r_b1 - RSSI_OFS) : 8'd0;
            r_lqi  <= is_radio ? r_b2 : 8'd0;
        end
        if (i_cmd.put) begin
            r_o_kind <= r_kind;
            r_o_code <= r_cmd;
            r_o_has  <= (r_n != 6'd0);
            r_o_data <= (r_n != 6'd0) ? r_rd_data : 8'd0;
            r_o_idx  <= r_idx;
            r_o_blen <= r_n;
            r_o_rssi <= r_rssi;
            r_o_lqi  <= r_lqi;
            r_o_ver  <= r_ver;
            r_o_last <= last_res;
            if (!last_res) r_idx <= r_idx + 6'd1;
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.frame_kind   = r_o_kind;
    assign o_res.resp_code    = r_o_code;
    assign o_res.has_data     = r_o_has;
    assign o_res.data_byte    = r_o_data;
    assign o_res.byte_index   = r_o_idx;
    assign o_res.body_length  = r_o_blen;
    assign o_res.rssi_dbm     = r_o_rssi;
    assign o_res.link_quality = r_o_lqi;
    assign o_res.fw_version   = r_o_ver;
    assign o_res.last         = r_o_last;

    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_has) |-> (r_o_blen == 6'd0 && r_o_last && r_o_idx == 6'd0))
        else $error("empty body marker malformed");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_has) |-> (r_o_idx < r_o_blen))
        else $error("byte index beyond body length");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_has) |-> (r_o_last == (r_o_idx == (r_o_blen - 6'd1))))
        else $error("last flag on wrong item");

endmodule

// File: rtl/uart_frame_deframer.sv
// After the checksum byte is taken, the first item of a run passes a store read (READ), then an
// output register load (PUT). Throughput: one received byte per cycle while parsing; replay
// gives each item as a store read, then output register load, while the sink keeps up.
// Input is held off during replay; the last item may wait while the next frame parses.
// Reset (i_rst_n low, synchronous) returns to start-byte hunt and clears the checksum, byte
// counter, length, output valid and firmware version; the frame store is not cleared.
// ----------------------------------------------------------------------------
// uart_frame_deframer
// Start-byte/length/XOR-checksum frame parser that replays radio payloads
// and command responses one byte per item.
// ----------------------------------------------------------------------------
module uart_frame_deframer import ufd_pkg::*; #(
    parameter int BUF_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ufd_in_if.sink    i_rx,
    ufd_out_if.source o_res
);

    t_ufd_cmd  cmd;
    t_ufd_stat stat;

    ufd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ufd_dp #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .o_res   (o_res),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule
